### hdl/qtl_pkg.sv
// Package with shared types, character constants and helpers for the quoted token lexer.
`default_nettype none

package qtl_pkg;

    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChNl     = 8'h0A;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChEq     = 8'h3D;
    localparam logic [7:0] ChLParen = 8'h28;
    localparam logic [7:0] ChRParen = 8'h29;
    localparam logic [7:0] ChComma  = 8'h2C;
    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChLowA   = 8'h61;
    localparam logic [7:0] ChLowZ   = 8'h7A;
    localparam logic [7:0] ChUpA    = 8'h41;

    localparam logic ReqChar = 1'b0;
    localparam logic ReqEos  = 1'b1;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        MODE_LEAD   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_PLAIN  = 2'd2,
        MODE_TRAIL  = 2'd3
    } t_mode;

    // One classified byte: an optional end marker, then an optional character.
    typedef struct packed {
        logic       has_end;
        logic       was_string;
        logic       eol_after;
        logic       has_char;
        logic [7:0] ch;
    } t_cmd;

    function automatic logic is_sep(input logic [7:0] c);
        is_sep = (c == ChSpace) || (c == ChNl) || (c == ChTab) || (c == ChEq) ||
                 (c == ChLParen) || (c == ChRParen) || (c == ChComma);
    endfunction

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        if (c >= ChLowA && c <= ChLowZ) begin
            fold_upper = c - ChLowA + ChUpA;
        end else begin
            fold_upper = c;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/qtl_front.sv
// Front end: accepts bytes, tracks lexer mode and classifies each byte into a command.
`default_nettype none

module qtl_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_req_type,
    input  wire  [7:0]        i_byte_value,
    input  wire               i_full,
    output logic              o_push,
    output qtl_pkg::t_cmd     o_cmd
);

    qtl_pkg::t_mode r_mode, n_mode;
    logic           r_str, n_str;
    logic           w_accept;
    logic           w_sep;
    logic           w_quote;
    logic [7:0]     w_fold;
    qtl_pkg::t_cmd  w_cmd;

    assign o_stall  = i_full;
    assign w_accept = i_valid && !i_full;
    assign w_sep    = qtl_pkg::is_sep(i_byte_value);
    assign w_quote  = (i_byte_value == qtl_pkg::ChQuote);
    assign w_fold   = qtl_pkg::fold_upper(i_byte_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= qtl_pkg::MODE_LEAD;
            r_str  <= 1'b0;
        end else if (w_accept) begin
            r_mode <= n_mode;
            r_str  <= n_str;
        end
    end

    always_comb begin
        w_cmd  = '0;
        n_mode = r_mode;
        n_str  = r_str;
        if (i_req_type == qtl_pkg::ReqEos) begin
            // Close any open token, then start over.
            if (r_mode != qtl_pkg::MODE_LEAD) begin
                w_cmd.has_end    = 1'b1;
                w_cmd.was_string = r_str;
            end
            n_mode = qtl_pkg::MODE_LEAD;
            n_str  = 1'b0;
        end else begin
            unique case (r_mode)
                qtl_pkg::MODE_LEAD: begin
                    if (!w_sep) begin
                        if (w_quote) begin
                            n_mode = qtl_pkg::MODE_STRING;
                            n_str  = 1'b1;
                        end else begin
                            n_mode         = qtl_pkg::MODE_PLAIN;
                            n_str          = 1'b0;
                            w_cmd.has_char = 1'b1;
                            w_cmd.ch       = w_fold;
                        end
                    end
                end
                qtl_pkg::MODE_STRING: begin
                    if (w_quote) begin
                        n_mode = qtl_pkg::MODE_TRAIL;
                    end else begin
                        w_cmd.has_char = 1'b1;
                        w_cmd.ch       = i_byte_value;
                    end
                end
                qtl_pkg::MODE_PLAIN: begin
                    if (i_byte_value == qtl_pkg::ChNl) begin
                        w_cmd.has_end    = 1'b1;
                        w_cmd.was_string = r_str;
                        w_cmd.eol_after  = 1'b1;
                        n_mode           = qtl_pkg::MODE_LEAD;
                        n_str            = 1'b0;
                    end else if (w_sep) begin
                        n_mode = qtl_pkg::MODE_TRAIL;
                    end else begin
                        w_cmd.has_char = 1'b1;
                        w_cmd.ch       = w_fold;
                    end
                end
                qtl_pkg::MODE_TRAIL: begin
                    if (i_byte_value == qtl_pkg::ChNl) begin
                        w_cmd.has_end    = 1'b1;
                        w_cmd.was_string = r_str;
                        w_cmd.eol_after  = 1'b1;
                        n_mode           = qtl_pkg::MODE_LEAD;
                        n_str            = 1'b0;
                    end else if (!w_sep) begin
                        w_cmd.has_end    = 1'b1;
                        w_cmd.was_string = r_str;
                        if (w_quote) begin
                            n_mode = qtl_pkg::MODE_STRING;
                            n_str  = 1'b1;
                        end else begin
                            n_mode         = qtl_pkg::MODE_PLAIN;
                            n_str          = 1'b0;
                            w_cmd.has_char = 1'b1;
                            w_cmd.ch       = w_fold;
                        end
                    end
                end
                default: begin
                    n_mode = qtl_pkg::MODE_LEAD;
                end
            endcase
        end
    end

    assign o_push = w_accept && (w_cmd.has_end || w_cmd.has_char);
    assign o_cmd  = w_cmd;

endmodule

`default_nettype wire

### hdl/qtl_queue.sv
// Small command queue that decouples the front end from the result stage.
`default_nettype none

module qtl_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  qtl_pkg::t_cmd     i_cmd,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_empty,
    output qtl_pkg::t_cmd     o_head
);

    qtl_pkg::t_cmd                r_mem [qtl_pkg::QDepth];
    logic [qtl_pkg::QPtrW-1:0]    r_wr_ptr;
    logic [qtl_pkg::QPtrW-1:0]    r_rd_ptr;
    logic [qtl_pkg::QCntW-1:0]    r_count;

    assign o_full  = (r_count == qtl_pkg::QCntW'(qtl_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/qtl_back.sv
// Back end: expands queued commands into one or two results in an output register.
`default_nettype none

module qtl_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_empty,
    input  qtl_pkg::t_cmd     i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_stall,
    output logic              o_is_token_end,
    output logic [7:0]        o_token_char,
    output logic              o_was_string,
    output logic              o_eol_after,
    output logic              o_last
);

    logic       r_valid;
    logic       r_phase;
    logic       r_is_end;
    logic [7:0] r_char;
    logic       r_ws;
    logic       r_eol;
    logic       r_last;
    logic       w_load;
    logic       w_take;
    logic       w_emit_end;

    assign w_load     = !r_valid || !i_stall;
    assign w_take     = w_load && !i_empty;
    assign w_emit_end = i_head.has_end && !r_phase;
    // Hold the entry after its end marker if a character still follows.
    assign o_pop      = w_take && !(w_emit_end && i_head.has_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else if (w_load) begin
            r_valid <= !i_empty;
            if (w_take) begin
                r_phase <= w_emit_end && i_head.has_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            if (w_emit_end) begin
                r_is_end <= 1'b1;
                r_char   <= 8'd0;
                r_ws     <= i_head.was_string;
                r_eol    <= i_head.eol_after;
                r_last   <= !i_head.has_char;
            end else begin
                r_is_end <= 1'b0;
                r_char   <= i_head.ch;
                r_ws     <= 1'b0;
                r_eol    <= 1'b0;
                r_last   <= 1'b1;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_is_token_end = r_is_end;
    assign o_token_char   = r_char;
    assign o_was_string   = r_ws;
    assign o_eol_after    = r_eol;
    assign o_last         = r_last;

endmodule

`default_nettype wire

### hdl/quoted_token_lexer.sv
// Top level of the quoted token lexer: front end, command queue and result stage.
`default_nettype none

//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | to block  | i_valid / o_stall  | i_req_type, i_byte_value
//  out     | from block| o_valid / i_stall  | o_is_token_end, o_token_char,
//          |           |                    | o_was_string, o_eol_after, o_last
//
//  One byte is taken per cycle while the command queue has room; the lexer mode
//  advances in the same cycle, so the next byte follows directly.
//  Results leave one per cycle from the output register while i_stall is low; a
//  byte that closes a token and opens the next (end marker plus character) gives two results.
//  A full queue (four commands) raises o_stall; a stalled output holds its
//  transfer and lets the queue fill. Synchronous active-low reset empties the
//  queue, drops the output transfer and returns the lexer to leading skip.

module quoted_token_lexer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_req_type,
    input  wire  [7:0]  i_byte_value,
    output logic        o_valid,
    input  wire         i_stall,
    output logic        o_is_token_end,
    output logic [7:0]  o_token_char,
    output logic        o_was_string,
    output logic        o_eol_after,
    output logic        o_last
);

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    qtl_pkg::t_cmd w_cmd;
    qtl_pkg::t_cmd w_head;

    // Classify each byte and advance the lexer mode.
    qtl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_byte_value (i_byte_value),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_cmd        (w_cmd)
    );

    // Buffer commands so the front end keeps going while results wait.
    qtl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // Expand each command into its results, end marker first.
    qtl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_token_end (o_is_token_end),
        .o_token_char   (o_token_char),
        .o_was_string   (o_was_string),
        .o_eol_after    (o_eol_after),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
